[rtl/open_heap_ring_tracker_top_defines.svh]
// assertion macros for the open heap ring tracker
`ifndef OPEN_HEAP_RING_TRACKER_TOP_DEFINES_SVH
`define OPEN_HEAP_RING_TRACKER_TOP_DEFINES_SVH

// checked on every rising clock edge outside reset
`define OHRT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define OHRT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/ohrt_pkg.sv]
package ohrt_pkg;

   localparam int RingEntries = 64;
   localparam int PtrWidth    = $clog2(RingEntries);
   localparam int CntWidth    = $clog2(RingEntries + 1);

   localparam int CounterWidth = 48;
   localparam int DestWidth    = 3;
   localparam int StampWidth   = 48;

   // operation codes
   localparam logic OpRecord   = 1'b0;
   localparam logic OpComplete = 1'b1;

   typedef struct packed {
      logic                    operation;
      logic [CounterWidth-1:0] heap_counter;
      logic [DestWidth-1:0]    destination;
      logic [StampWidth-1:0]   timestamp;
   } req_item_type;

   typedef struct packed {
      logic                  found_flag;
      logic [DestWidth-1:0]  looked_up_destination;
      logic [StampWidth-1:0] looked_up_timestamp;
   } rsp_item_type;

   typedef struct packed {
      logic [CounterWidth-1:0] heap_counter;
      logic [DestWidth-1:0]    destination;
      logic [StampWidth-1:0]   timestamp;
   } ring_entry_type;

   typedef struct packed {
      logic                wr_en;
      logic [PtrWidth-1:0] wr_addr;
      ring_entry_type      wr_data;
      logic                rd_en;
      logic [PtrWidth-1:0] rd_addr;
   } mem_req_type;

endpackage

[rtl/ohrt_ring_mem.sv]
module ohrt_ring_mem
   import ohrt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  mem_req_type    mem_req,
   output ring_entry_type rd_data
);

   ring_entry_type           ring_mem_ff [RingEntries];
   logic [RingEntries-1:0]   entry_valid_ff;
   ring_entry_type           rd_data_ff;
   logic                     rd_valid_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         ring_mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= ring_mem_ff[mem_req.rd_addr];
      end
   end

   // written marks, so that untouched entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            entry_valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rd_valid_ff <= entry_valid_ff[mem_req.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

[rtl/ohrt_search_ctrl.sv]
module ohrt_search_ctrl
   import ohrt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_item_type         req_item,
   input  logic [DestWidth-1:0] miss_dest,
   output mem_req_type          mem_req,
   input  ring_entry_type       rd_data,
   output logic                 res_valid,
   output rsp_item_type         res_item,
   input  logic                 res_take
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DONE
   } state_type;

   state_type               state_ff;
   logic [PtrWidth-1:0]     wr_ptr_ff;
   logic [PtrWidth-1:0]     newest_ff;
   logic [PtrWidth-1:0]     scan_addr_ff;
   logic [CntWidth-1:0]     issue_cnt_ff;
   logic                    pend_ff;
   logic [PtrWidth-1:0]     pend_addr_ff;
   logic                    pend_last_ff;
   logic [CounterWidth-1:0] key_ff;
   rsp_item_type            result_ff;
   logic                    accept;
   logic                    rd_issue;
   logic                    hit;

   function automatic logic [PtrWidth-1:0] ring_prev(input logic [PtrWidth-1:0] p);
      return (p == '0) ? PtrWidth'(RingEntries - 1) : p - 1'b1;
   endfunction

   function automatic logic [PtrWidth-1:0] ring_next(input logic [PtrWidth-1:0] p);
      return (p == PtrWidth'(RingEntries - 1)) ? '0 : p + 1'b1;
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rd_issue  = (state_ff == ST_SEARCH) && (issue_cnt_ff != CntWidth'(RingEntries));
   assign hit       = pend_ff && (rd_data.heap_counter == key_ff);

   always_comb begin
      mem_req.wr_en                = accept && (req_item.operation == OpRecord);
      mem_req.wr_addr              = wr_ptr_ff;
      mem_req.wr_data.heap_counter = req_item.heap_counter;
      mem_req.wr_data.destination  = req_item.destination;
      mem_req.wr_data.timestamp    = req_item.timestamp;
      mem_req.rd_en                = rd_issue;
      mem_req.rd_addr              = scan_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         wr_ptr_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_item.operation == OpRecord) begin
                     wr_ptr_ff <= ring_next(wr_ptr_ff);
                  end else begin
                     key_ff       <= req_item.heap_counter;
                     newest_ff    <= ring_prev(wr_ptr_ff);
                     scan_addr_ff <= ring_prev(wr_ptr_ff);
                     issue_cnt_ff <= '0;
                     pend_ff      <= 1'b0;
                     state_ff     <= ST_SEARCH;
                  end
               end
            end
            ST_SEARCH: begin
               // a read issued this cycle becomes pending unless the search ends this cycle
               pend_ff      <= rd_issue && !hit && !(pend_ff && pend_last_ff);
               pend_addr_ff <= scan_addr_ff;
               pend_last_ff <= (issue_cnt_ff == CntWidth'(RingEntries - 1));
               if (rd_issue) begin
                  scan_addr_ff <= ring_prev(scan_addr_ff);
                  issue_cnt_ff <= issue_cnt_ff + 1'b1;
               end
               if (hit) begin
                  result_ff.found_flag            <= 1'b1;
                  result_ff.looked_up_destination <= rd_data.destination;
                  result_ff.looked_up_timestamp   <= rd_data.timestamp;
                  if (pend_addr_ff == newest_ff) begin
                     wr_ptr_ff <= newest_ff;
                  end
                  state_ff <= ST_DONE;
               end else if (pend_ff && pend_last_ff) begin
                  result_ff.found_flag            <= 1'b0;
                  result_ff.looked_up_destination <= miss_dest;
                  result_ff.looked_up_timestamp   <= '0;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (res_take) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign res_valid = (state_ff == ST_DONE);
   assign res_item  = result_ff;

endmodule

[rtl/open_heap_ring_tracker_top.sv]
// open heap ring tracker: a ring of the 64 most recently opened heaps
// req channel (req_valid / req_stall / req_item) takes one transaction per item:
//   operation record stores counter, destination and timestamp at the write
//   pointer and advances it; it gives no response and leaves the block idle, so
//   records may follow each other back to back
//   operation complete scans the ring backward from the newest entry, one
//   memory read per cycle, and gives exactly one rsp transaction
// a complete holds req_stall high until its result goes to the output
//   register, which a stalled full output register delays; the scan reads
//   one entry at a time through the single read port, which sets this pace
// rsp channel (rsp_valid / rsp_stall / rsp_item) is a registered output; a
//   waiting response does not block further records, and a following complete
//   waits in its final state until the output register is free
// csr channel writes the trash destination, always ready
// reset (synchronous, active high) empties the ring, clears the write
//   pointer and trash destination and drops any response in flight
// a stalled response holds its payload until taken
module open_heap_ring_tracker_top
   import ohrt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request transactions
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_item_type         req_item,
   // response transactions
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_item_type         rsp_item,
   // trash destination register write
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [DestWidth-1:0] csr_wdata
);

   logic [DestWidth-1:0] miss_dest_ff;
   mem_req_type          mem_req;
   ring_entry_type       rd_data;
   logic                 res_valid;
   rsp_item_type         res_item;
   logic                 res_take;
   logic                 rsp_valid_ff;
   rsp_item_type         rsp_item_ff;

   // configuration register, write always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         miss_dest_ff <= '0;
      end else if (csr_valid) begin
         miss_dest_ff <= csr_wdata;
      end
   end

   // ring storage: counter, destination and timestamp per entry
   ohrt_ring_mem u_ring_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // write pointer, backward scan and result forming
   ohrt_search_ctrl u_search_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .miss_dest (miss_dest_ff),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res_item  (res_item),
      .res_take  (res_take)
   );

   // output register: load when empty or being drained this cycle
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_item_ff <= res_item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

[rtl/ohrt_checker.sv]
`include "open_heap_ring_tracker_top_defines.svh"

module ohrt_checker
   import ohrt_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_item_type req_item,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_item
);

   logic rsp_wait;
   logic rsp_miss;
   logic take_complete;

   assign rsp_wait      = rsp_valid && rsp_stall;
   assign rsp_miss      = rsp_valid && !rsp_item.found_flag;
   assign take_complete = req_valid && !req_stall && (req_item.operation == OpComplete);

   // no response survives a reset
   `OHRT_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "response valid after reset")

   // a stalled response keeps valid and payload
   `OHRT_ASSERT(a_rsp_hold, rsp_wait |=> rsp_valid && $stable(rsp_item), "stalled rsp changed")

   // a miss reports a zero timestamp
   `OHRT_ASSERT(a_miss_zero_stamp, rsp_miss |-> rsp_item.looked_up_timestamp == '0, "miss stamp")

   // an accepted complete starts a search that holds off the next request
   `OHRT_ASSERT(a_complete_busy, take_complete |=> req_stall, "request taken during search")

endmodule

bind open_heap_ring_tracker_top ohrt_checker u_ohrt_checker (.*);

[test/tb_top.sv]
module tb_top;
   import ohrt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CounterWidth-1:0] MaxCounter = {CounterWidth{1'b1}};
   localparam logic [StampWidth-1:0]   MaxStamp   = {StampWidth{1'b1}};
   localparam int                      DrainCycles = RingEntries + 8;

   // clock, reset and the ports of the block
   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_item_type         req_item  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_item_type         rsp_item;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [DestWidth-1:0] csr_wdata = '0;

   open_heap_ring_tracker_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // our own copy of the ring, pointer and trash destination
   logic [CounterWidth-1:0] ring_counter [RingEntries];
   logic [DestWidth-1:0]    ring_dest    [RingEntries];
   logic [StampWidth-1:0]   ring_stamp   [RingEntries];
   logic [PtrWidth-1:0]     ring_wptr;
   logic [DestWidth-1:0]    miss_dest;

   // lookups still owed by the block, oldest first
   rsp_item_type lookup_expect [$];
   // heap events waiting to be offered on the req channel
   req_item_type heap_events [$];
   // counters recently recorded, so that completes mostly hit
   logic [CounterWidth-1:0] recent_counters [$];

   int errors        = 0;
   int n_records     = 0;
   int n_completes   = 0;
   int n_hits        = 0;
   int n_misses      = 0;
   int n_trash_write = 0;
   int gap_left      = 0;
   int burst_left    = 1;

   // long receiver hold-off, armed once by the stimulus
   bit long_hold_arm  = 1'b0;
   bit long_hold_done = 1'b0;

   initial begin
      for (int i = 0; i < RingEntries; i++) begin
         ring_counter[i] = '0;
         ring_dest[i]    = '0;
         ring_stamp[i]   = '0;
      end
      ring_wptr = '0;
      miss_dest = '0;
   end

   // works out what one accepted heap event does to the ring and what it returns
   task automatic track_heap_event(input req_item_type ev);
      logic [PtrWidth-1:0] newest;
      logic [PtrWidth-1:0] idx;
      rsp_item_type        res;
      bit                  hit;
      int                  n;
      if (ev.operation == OpRecord) begin
         ring_counter[ring_wptr] = ev.heap_counter;
         ring_dest[ring_wptr]    = ev.destination;
         ring_stamp[ring_wptr]   = ev.timestamp;
         // pointer is exactly PtrWidth bits wide, so it wraps by itself
         ring_wptr = ring_wptr + 1'b1;
         n_records++;
      end else begin
         newest = ring_wptr - 1'b1;
         idx    = newest;
         hit    = 1'b0;
         res    = '0;
         for (n = 0; n < RingEntries && !hit; n++) begin
            if (ring_counter[idx] == ev.heap_counter) begin
               hit                       = 1'b1;
               res.found_flag            = 1'b1;
               res.looked_up_destination = ring_dest[idx];
               res.looked_up_timestamp   = ring_stamp[idx];
               // newest entry taken: the next record overwrites it
               if (idx == newest)
                  ring_wptr = newest;
            end else begin
               idx = idx - 1'b1;
            end
         end
         if (!hit) begin
            res.found_flag            = 1'b0;
            res.looked_up_destination = miss_dest;
            res.looked_up_timestamp   = '0;
            n_misses++;
         end else begin
            n_hits++;
         end
         lookup_expect.push_back(res);
         n_completes++;
      end
   endtask

   // ---------------------------------------------------------------------
   // req driver: bursts of random length, random gaps between them
   // a stalled transaction keeps valid and payload untouched
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      if (req_valid && !req_stall)
         track_heap_event(req_item);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (heap_events.size() > 0) begin
            req_item  <= heap_events.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 12);
               // about a quarter of the bursts run straight into the next one
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // rsp stall pattern: modes of random length (free flowing, light,
   // heavy, periodic), plus one long hold-off counted here in cycles
   // ---------------------------------------------------------------------
   int stall_mode   = 0;
   int mode_left    = 0;
   int stall_period = 2;
   int hold_left    = 0;
   int rx_cycle     = 0;

   always @(posedge clock) begin : rsp_stall_pattern
      logic stall_next;
      rx_cycle++;
      if (long_hold_arm && !long_hold_done) begin
         long_hold_done = 1'b1;
         hold_left      = 600;
      end
      if (hold_left > 0) begin
         hold_left--;
         stall_next = 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode   = $urandom_range(0, 3);
            mode_left    = $urandom_range(20, 200);
            stall_period = $urandom_range(2, 6);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: stall_next = 1'b0;
            1: stall_next = ($urandom_range(0, 99) < 30);
            2: stall_next = ($urandom_range(0, 99) < 70);
            default: stall_next = ((rx_cycle % stall_period) == 0);
         endcase
      end
      rsp_stall <= stall_next;
   end

   // ---------------------------------------------------------------------
   // rsp monitor: every accepted transaction against the oldest lookup owed
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lookup_expect.size() == 0) begin
            $display("%0t: unexpected rsp transaction, expected none, actual %h",
                     $realtime, rsp_item);
            errors++;
         end else begin
            want = lookup_expect.pop_front();
            if (rsp_item.found_flag !== want.found_flag) begin
               $display("%0t: found_flag mismatch, expected %0d, actual %0d",
                        $realtime, want.found_flag, rsp_item.found_flag);
               errors++;
            end
            if (rsp_item.looked_up_destination !== want.looked_up_destination) begin
               $display("%0t: looked_up_destination mismatch, expected %0d, actual %0d",
                        $realtime, want.looked_up_destination,
                        rsp_item.looked_up_destination);
               errors++;
            end
            if (rsp_item.looked_up_timestamp !== want.looked_up_timestamp) begin
               $display("%0t: looked_up_timestamp mismatch, expected %h, actual %h",
                        $realtime, want.looked_up_timestamp, rsp_item.looked_up_timestamp);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   function automatic req_item_type heap_event(input logic op,
                                               input logic [CounterWidth-1:0] cnt,
                                               input logic [DestWidth-1:0] dst,
                                               input logic [StampWidth-1:0] ts);
      req_item_type ev;
      ev.operation    = op;
      ev.heap_counter = cnt;
      ev.destination  = dst;
      ev.timestamp    = ts;
      return ev;
   endfunction

   // sender pauses until the block owes nothing, then lets a full scan pass,
   // since a trailing record gives no transaction to wait for
   task automatic wait_drained();
      while (heap_events.size() != 0 || req_valid || lookup_expect.size() != 0)
         @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_miss_dest(input logic [DestWidth-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      miss_dest = value;
      n_trash_write++;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // mostly records of a small counter pool (duplicates) and completes of
   // counters recently recorded, the rest random or edge counters
   task automatic push_random_event();
      logic [63:0]             wide_cnt;
      logic [63:0]             wide_ts;
      logic [CounterWidth-1:0] cnt;
      int                      pick;
      int                      k;
      wide_cnt = {$urandom(), $urandom()};
      wide_ts  = {$urandom(), $urandom()};
      pick     = $urandom_range(0, 99);
      if (pick < 55) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: cnt = CounterWidth'($urandom_range(0, 15));
            5, 6, 7:       cnt = wide_cnt[CounterWidth-1:0];
            default: begin
               k   = $urandom_range(0, CounterWidth - 1);
               cnt = ($urandom_range(0, 1) == 1) ? (48'h1 << k) : ~(48'h1 << k);
            end
         endcase
         recent_counters.push_back(cnt);
         if (recent_counters.size() > 96)
            void'(recent_counters.pop_front());
         heap_events.push_back(heap_event(OpRecord, cnt, DestWidth'($urandom_range(0, 7)),
                                          wide_ts[StampWidth-1:0]));
      end else begin
         if (pick < 85 && recent_counters.size() > 0)
            cnt = recent_counters[$urandom_range(0, recent_counters.size() - 1)];
         else if (pick < 90)
            cnt = '0;
         else
            cnt = wide_cnt[CounterWidth-1:0];
         // destination and timestamp are random here and must be ignored
         heap_events.push_back(heap_event(OpComplete, cnt, DestWidth'($urandom_range(0, 7)),
                                          wide_ts[StampWidth-1:0]));
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   logic [DestWidth-1:0] trash_plan [4];

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, trash destination still at its reset value
      // counter zero straight after reset hits the unwritten newest entry,
      // and the pointer steps back across the wrap
      heap_events.push_back(heap_event(OpComplete, '0, 3'd5, 48'h1234_5678_9abc));
      heap_events.push_back(heap_event(OpComplete, MaxCounter, '0, '0));
      heap_events.push_back(heap_event(OpRecord, MaxCounter, 3'd7, MaxStamp));
      heap_events.push_back(heap_event(OpRecord, 48'h5, 3'd0, '0));
      heap_events.push_back(heap_event(OpRecord, 48'ha5a5_a5a5_a5a5, 3'd5, 48'h5a5a_5a5a_5a5a));
      // hit on an older entry, then a hit on the newest one
      heap_events.push_back(heap_event(OpComplete, MaxCounter, '0, '0));
      heap_events.push_back(heap_event(OpComplete, 48'ha5a5_a5a5_a5a5, 3'd7, MaxStamp));
      // duplicate counter: the newest copy must win
      heap_events.push_back(heap_event(OpRecord, MaxCounter, 3'd2, 48'h1));
      heap_events.push_back(heap_event(OpComplete, MaxCounter, '0, '0));
      heap_events.push_back(heap_event(OpComplete, MaxCounter, '0, '0));
      heap_events.push_back(heap_event(OpComplete, '0, '0, '0));
      heap_events.push_back(heap_event(OpRecord, '0, 3'd3, 48'h8000_0000_0000));
      heap_events.push_back(heap_event(OpComplete, '0, '0, '0));
      heap_events.push_back(heap_event(OpComplete, 48'h1, 3'd7, MaxStamp));
      heap_events.push_back(heap_event(OpRecord, 48'h8000_0000_0000, 3'd6, 48'h7fff_ffff_ffff));
      heap_events.push_back(heap_event(OpRecord, 48'h7fff_ffff_ffff, 3'd1, 48'h2));
      heap_events.push_back(heap_event(OpComplete, 48'h8000_0000_0000, '0, '0));
      wait_drained();

      // misses now report the highest trash code
      write_miss_dest(3'd7);
      heap_events.push_back(heap_event(OpComplete, MaxCounter - 1'b1, '0, '0));
      heap_events.push_back(heap_event(OpComplete, 48'h0123_4567_89ab, 3'd4, 48'h3));
      heap_events.push_back(heap_event(OpComplete, 48'h7fff_ffff_ffff, '0, '0));
      wait_drained();

      // random phases, each under its own trash destination
      trash_plan[0] = 3'd0;
      trash_plan[1] = DestWidth'($urandom_range(1, 6));
      trash_plan[2] = 3'd7;
      trash_plan[3] = DestWidth'($urandom_range(0, 7));
      for (int phase = 0; phase < 4; phase++) begin
         write_miss_dest(trash_plan[phase]);
         for (int i = 0; i < 135; i++)
            push_random_event();
         // hold the receiver off for a long stretch while requests keep coming,
         // so the output register fills and req_stall backs up
         if (phase == 1)
            long_hold_arm = 1'b1;
         wait_drained();
      end

      $display("run covered %0d records and %0d completes (%0d hits, %0d misses)",
               n_records, n_completes, n_hits, n_misses);
      $display("over %0d trash destination writes, including a long receiver hold-off",
               n_trash_write);
      if (errors == 0 && lookup_expect.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog: far beyond the slowest correct run
   initial begin
      #1000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
